// ----- rtl/core/icy_pkg.sv -----
// shared types and constants for the indexed color to ycbcr lookup
`timescale 1ns / 1ps

package icy_pkg;

  // input item kind
  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  localparam int unsigned PALETTE_ENTRIES_DEF = 256;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned TripleW = 3 * ChanW;
  localparam int unsigned IndexW = 8;

  // bt.601 weights scaled by 65536, truncated; sums fit in 25 bits
  localparam int unsigned SumW = 25;

  localparam logic [SumW-1:0] COEF_Y_R  = 25'd19595;
  localparam logic [SumW-1:0] COEF_Y_G  = 25'd38469;
  localparam logic [SumW-1:0] COEF_Y_B  = 25'd7471;
  localparam logic [SumW-1:0] COEF_CB_R = 25'd11058;
  localparam logic [SumW-1:0] COEF_CB_G = 25'd21709;
  localparam logic [SumW-1:0] COEF_CB_B = 25'd32768;
  localparam logic [SumW-1:0] COEF_CR_R = 25'd32768;
  localparam logic [SumW-1:0] COEF_CR_G = 25'd27439;
  localparam logic [SumW-1:0] COEF_CR_B = 25'd5328;
  localparam logic [SumW-1:0] CHROMA_OFFSET = 25'd8388608;

endpackage

// ----- rtl/core/icy_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module icy_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/icy_ycc.sv -----
// rgb to ycbcr conversion, fixed point weighted sums
`timescale 1ns / 1ps

module icy_ycc (
  input  logic [icy_pkg::ChanW-1:0] red_i,
  input  logic [icy_pkg::ChanW-1:0] green_i,
  input  logic [icy_pkg::ChanW-1:0] blue_i,
  output logic [icy_pkg::ChanW-1:0] luma_o,
  output logic [icy_pkg::ChanW-1:0] chroma_blue_o,
  output logic [icy_pkg::ChanW-1:0] chroma_red_o
);

  logic [icy_pkg::SumW-1:0] r_ext, g_ext, b_ext;
  logic [icy_pkg::SumW-1:0] y_sum, cb_sum, cr_sum;

  assign r_ext = icy_pkg::SumW'(red_i);
  assign g_ext = icy_pkg::SumW'(green_i);
  assign b_ext = icy_pkg::SumW'(blue_i);

  // chroma sums never go negative, so add the positive terms first
  always_comb begin
    y_sum  = icy_pkg::COEF_Y_R * r_ext + icy_pkg::COEF_Y_G * g_ext
           + icy_pkg::COEF_Y_B * b_ext;
    cb_sum = (icy_pkg::CHROMA_OFFSET + icy_pkg::COEF_CB_B * b_ext)
           - (icy_pkg::COEF_CB_R * r_ext + icy_pkg::COEF_CB_G * g_ext);
    cr_sum = (icy_pkg::CHROMA_OFFSET + icy_pkg::COEF_CR_R * r_ext)
           - (icy_pkg::COEF_CR_G * g_ext + icy_pkg::COEF_CR_B * b_ext);
  end

  assign luma_o        = y_sum[23:16];
  assign chroma_blue_o = cb_sum[23:16];
  assign chroma_red_o  = cr_sum[23:16];

endmodule

// ----- rtl/core/indexed_color_to_ycbcr_lookup_core.sv -----
// top level: palette store with rgb to ycbcr conversion on write
//
//  channel  | ports                                               | beat taken when
//  ---------+-----------------------------------------------------+------------------
//  command  | kind_i entry_index_i red_in_i green_in_i blue_in_i  | start_i && !busy_o
//  result   | luma_o chroma_blue_o chroma_red_o red_out_o ...     | valid_o
//
//  one command beat per cycle; busy_o stays low
//  a lookup returns its result through the input register, then the registered
//  read of the palette rams; a write produces no result
//  the conversion sits between the input register and the ram write port
//  reset clears only the control flops; palette contents are undefined until written
//  the receiver cannot stall: valid_o is a one-cycle strobe
`timescale 1ns / 1ps

module indexed_color_to_ycbcr_lookup_core #(
  parameter int unsigned PALETTE_ENTRIES = icy_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              kind_i,
  input  logic [icy_pkg::IndexW-1:0]        entry_index_i,
  input  logic [icy_pkg::ChanW-1:0]         red_in_i,
  input  logic [icy_pkg::ChanW-1:0]         green_in_i,
  input  logic [icy_pkg::ChanW-1:0]         blue_in_i,
  output logic                              valid_o,
  output logic [icy_pkg::ChanW-1:0]         luma_o,
  output logic [icy_pkg::ChanW-1:0]         chroma_blue_o,
  output logic [icy_pkg::ChanW-1:0]         chroma_red_o,
  output logic [icy_pkg::ChanW-1:0]         red_out_o,
  output logic [icy_pkg::ChanW-1:0]         green_out_o,
  output logic [icy_pkg::ChanW-1:0]         blue_out_o
);

  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES);

  logic accept;
  logic in_range_d;
  logic wr_d, wr_q;
  logic lk_d, lk_q;
  logic valid_q;
  logic in_range_q;
  logic zero_q;
  logic [icy_pkg::IndexW-1:0] idx_q;
  logic [icy_pkg::ChanW-1:0]  red_q, green_q, blue_q;
  logic [icy_pkg::ChanW-1:0]  y_val, cb_val, cr_val;
  logic [AddrW-1:0]           addr;
  logic [icy_pkg::TripleW-1:0] ycc_rdata, rgb_rdata;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign in_range_d = ({1'b0, entry_index_i} < (icy_pkg::IndexW + 1)'(PALETTE_ENTRIES));
  assign wr_d = accept && (icy_pkg::kind_e'(kind_i) == icy_pkg::KIND_WRITE);
  assign lk_d = accept && (icy_pkg::kind_e'(kind_i) == icy_pkg::KIND_LOOKUP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      lk_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      wr_q    <= wr_d && in_range_d;
      lk_q    <= lk_d;
      valid_q <= lk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q      <= entry_index_i;
      red_q      <= red_in_i;
      green_q    <= green_in_i;
      blue_q     <= blue_in_i;
      in_range_q <= in_range_d;
    end
    // out of range lookups answer zero
    zero_q <= !in_range_q;
  end

  assign addr = idx_q[AddrW-1:0];

  icy_ycc u_ycc (
    .red_i         (red_q),
    .green_i       (green_q),
    .blue_i        (blue_q),
    .luma_o        (y_val),
    .chroma_blue_o (cb_val),
    .chroma_red_o  (cr_val)
  );

  icy_ram #(
    .WIDTH (icy_pkg::TripleW),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ycc_ram (
    .clk_i   (clk_i),
    .we_i    (wr_q),
    .waddr_i (addr),
    .wdata_i ({y_val, cb_val, cr_val}),
    .raddr_i (addr),
    .rdata_o (ycc_rdata)
  );

  icy_ram #(
    .WIDTH (icy_pkg::TripleW),
    .DEPTH (PALETTE_ENTRIES)
  ) u_rgb_ram (
    .clk_i   (clk_i),
    .we_i    (wr_q),
    .waddr_i (addr),
    .wdata_i ({red_q, green_q, blue_q}),
    .raddr_i (addr),
    .rdata_o (rgb_rdata)
  );

  assign valid_o       = valid_q;
  assign luma_o        = zero_q ? '0 : ycc_rdata[23:16];
  assign chroma_blue_o = zero_q ? '0 : ycc_rdata[15:8];
  assign chroma_red_o  = zero_q ? '0 : ycc_rdata[7:0];
  assign red_out_o     = zero_q ? '0 : rgb_rdata[23:16];
  assign green_out_o   = zero_q ? '0 : rgb_rdata[15:8];
  assign blue_out_o    = zero_q ? '0 : rgb_rdata[7:0];

`ifndef SYNTHESIS
  // every result beat comes from a lookup beat, by way of lk_q and then valid_q
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(lk_d, 2))
    else $error("result beat without a lookup beat");

  // a palette write never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_d |=> ##1 !valid_o)
    else $error("palette write produced a result beat");

  // a lookup right behind a write to the same entry sees the new color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_d && in_range_d) ##1 (lk_d && (entry_index_i == $past(entry_index_i)))
    |-> ##2 (valid_o && (red_out_o == $past(red_in_i, 3))
             && (green_out_o == $past(green_in_i, 3))
             && (blue_out_o == $past(blue_in_i, 3))))
    else $error("lookup missed the preceding palette write");
`endif

endmodule
